// File: design/four_corner_gradient_pixel_unit_defines.svh
// ----------------------------------------------------------------------------
// four corner gradient pixel unit - assertion macros
// Concurrent assertion helpers, empty when synthesized.
// ----------------------------------------------------------------------------
`ifndef FOUR_CORNER_GRADIENT_PIXEL_UNIT_DEFINES_SVH
`define FOUR_CORNER_GRADIENT_PIXEL_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FCG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcg assertion failed");

// next-cycle implication
`define FCG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcg assertion failed");

`else

`define FCG_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define FCG_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: design/fcg_pkg.sv
// ----------------------------------------------------------------------------
// fcg_pkg
// Shared constants, register codes and pipeline types of the gradient unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fcg_pkg;

  localparam int unsigned MAX_DIM    = 4096;
  localparam int unsigned CFG_DIM_W  = 13;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned DIM_W      = $clog2(MAX_DIM) + 1;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned NUM_CHAN   = 3;
  localparam int unsigned NUM_CORNER = 4;
  localparam int unsigned LEFT_W     = CHAN_W + DIM_W;
  localparam int unsigned D_W        = 2 * DIM_W;
  localparam int unsigned NUM_W      = D_W + CHAN_W;
  localparam int unsigned CFG_ADDR_W = 3;
  // three mix stages, one divider cell per quotient bit, output register
  localparam int unsigned PIPE_LAT   = 3 + CHAN_W + 1;

  localparam logic [CHAN_W-1:0] ALPHA = 8'hFF;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_CORNER_0     = 3'd2,
    CFG_CORNER_1     = 3'd3,
    CFG_CORNER_2     = 3'd4,
    CFG_CORNER_3     = 3'd5
  } cfg_reg_e;

  // partial remainders and quotients of the three channels plus divisor
  typedef struct packed {
    logic [D_W-1:0]                     dvs;
    logic [NUM_CHAN-1:0][NUM_W-1:0]     rem;
    logic [NUM_CHAN-1:0][CHAN_W-1:0]    quo;
  } div_data_t;

  // zero reads as one, oversized reads as the maximum
  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (32'(d) > 32'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(d);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/four_corner_gradient_pixel_unit.sv
// ----------------------------------------------------------------------------
// four_corner_gradient_pixel_unit
// Bilinear gradient from four corner colors, one RGBA pixel per request.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: write image width, image height and the four corner
//   words on the cfg channel (cfg_ready_o is always high) while no item is
//   in flight.
//   Requests: pulse start_i with pixel_x_i / pixel_y_i; busy_o stays low,
//   so an item is taken in every cycle that start_i is high.
//   Results: done_o strobes for one cycle with pixel_rgba_o once the item
//   has passed every pipeline register below, in request order.
//   Throughput: one pixel per clock. Latency is three mix stages (clamp,
//   vertical products, horizontal products), eight divider cells, one per
//   quotient bit, and the output register.
//   The receiver cannot stall; every result is shown once.
//   Reset: width and height read as one, corners as zero, pipeline empty.
// ----------------------------------------------------------------------------
`default_nettype none

`include "four_corner_gradient_pixel_unit_defines.svh"

module four_corner_gradient_pixel_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [fcg_pkg::COORD_W-1:0]        pixel_x_i,
  input  logic [fcg_pkg::COORD_W-1:0]        pixel_y_i,
  output logic                               done_o,
  output logic [fcg_pkg::WORD_W-1:0]         pixel_rgba_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [fcg_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [fcg_pkg::WORD_W-1:0]         cfg_data_i
);
  import fcg_pkg::*;

  logic [CFG_DIM_W-1:0]                 width_q, height_q;
  logic [NUM_CORNER-1:0][WORD_W-1:0]    corner_q;
  logic [DIM_W-1:0]                     dim_w, dim_h;

  logic [CHAN_W:0] cell_vld;
  div_data_t       cell_data [CHAN_W+1];

  logic              done_q;
  logic [WORD_W-1:0] pixel_d, pixel_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_DIM_W'(1);
      height_q <= CFG_DIM_W'(1);
      corner_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_addr_i)
        CFG_IMAGE_WIDTH:  width_q     <= cfg_data_i[CFG_DIM_W-1:0];
        CFG_IMAGE_HEIGHT: height_q    <= cfg_data_i[CFG_DIM_W-1:0];
        CFG_CORNER_0:     corner_q[0] <= cfg_data_i;
        CFG_CORNER_1:     corner_q[1] <= cfg_data_i;
        CFG_CORNER_2:     corner_q[2] <= cfg_data_i;
        CFG_CORNER_3:     corner_q[3] <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign dim_w = eff_dim(width_q);
  assign dim_h = eff_dim(height_q);

  fcg_mix u_mix (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (start_i && !busy_o),
    .pixel_x_i (pixel_x_i),
    .pixel_y_i (pixel_y_i),
    .dim_w_i   (dim_w),
    .dim_h_i   (dim_h),
    .corner_i  (corner_q),
    .vld_o     (cell_vld[0]),
    .data_o    (cell_data[0])
  );

  for (genvar i = 0; i < CHAN_W; i++) begin : g_cell
    fcg_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (cell_vld[i]),
      .data_i (cell_data[i]),
      .vld_o  (cell_vld[i+1]),
      .data_o (cell_data[i+1])
    );
  end

  assign pixel_d = {cell_data[CHAN_W].quo[0], cell_data[CHAN_W].quo[1],
                    cell_data[CHAN_W].quo[2], ALPHA};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cell_vld[CHAN_W];
    end
  end

  always_ff @(posedge clk_i) begin
    pixel_q <= pixel_d;
  end

  assign done_o       = done_q;
  assign pixel_rgba_o = pixel_q;

  `FCG_ASSERT_IMP(a_req_done, clk_i, rst_ni, start_i && !busy_o, ##PIPE_LAT done_o)
  `FCG_ASSERT_IMP(a_done_req, clk_i, rst_ni, done_o, $past(start_i && !busy_o, PIPE_LAT))
  `FCG_ASSERT_IMP(a_w_range, clk_i, rst_ni, 1'b1, (dim_w != '0) && (dim_w <= DIM_W'(MAX_DIM)))
  `FCG_ASSERT_IMP(a_h_range, clk_i, rst_ni, 1'b1, (dim_h != '0) && (dim_h <= DIM_W'(MAX_DIM)))

endmodule

`default_nettype wire

// File: design/fcg_mix.sv
// ----------------------------------------------------------------------------
// fcg_mix
// Clamps the coordinate and forms the bilinear numerator and divisor
// over three pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

module fcg_mix (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              vld_i,
  input  logic [fcg_pkg::COORD_W-1:0]                       pixel_x_i,
  input  logic [fcg_pkg::COORD_W-1:0]                       pixel_y_i,
  input  logic [fcg_pkg::DIM_W-1:0]                         dim_w_i,
  input  logic [fcg_pkg::DIM_W-1:0]                         dim_h_i,
  input  logic [fcg_pkg::NUM_CORNER-1:0][fcg_pkg::WORD_W-1:0] corner_i,
  output logic                                              vld_o,
  output fcg_pkg::div_data_t                                data_o
);
  import fcg_pkg::*;

  function automatic logic [CHAN_W-1:0] chan_of(input logic [WORD_W-1:0] word,
                                                input int unsigned ch);
    return CHAN_W'(word >> (WORD_W - CHAN_W * (ch + 1)));
  endfunction

  // stage a: clamped coordinate and complements
  logic             a_vld_q;
  logic [DIM_W-1:0] a_x_d, a_y_d, a_x_q, a_y_q, a_wx_q, a_hy_q, a_w_q, a_h_q;

  // stage b: vertical mixes and divisor
  logic                             b_vld_q;
  logic [NUM_CHAN-1:0][LEFT_W-1:0]  b_left_d, b_right_d, b_left_q, b_right_q;
  logic [DIM_W-1:0]                 b_x_q, b_wx_q;
  logic [D_W-1:0]                   b_dvs_q;

  // stage c: horizontal mix
  logic      c_vld_q;
  div_data_t c_data_d, c_data_q;

  always_comb begin
    a_x_d = (32'(pixel_x_i) >= 32'(dim_w_i)) ? dim_w_i - DIM_W'(1) : DIM_W'(pixel_x_i);
    a_y_d = (32'(pixel_y_i) >= 32'(dim_h_i)) ? dim_h_i - DIM_W'(1) : DIM_W'(pixel_y_i);
  end

  always_comb begin
    for (int unsigned c = 0; c < NUM_CHAN; c++) begin
      b_left_d[c]  = LEFT_W'(chan_of(corner_i[0], c)) * LEFT_W'(a_y_q)
                   + LEFT_W'(chan_of(corner_i[1], c)) * LEFT_W'(a_hy_q);
      b_right_d[c] = LEFT_W'(chan_of(corner_i[3], c)) * LEFT_W'(a_y_q)
                   + LEFT_W'(chan_of(corner_i[2], c)) * LEFT_W'(a_hy_q);
    end
  end

  always_comb begin
    c_data_d.dvs = b_dvs_q;
    for (int unsigned c = 0; c < NUM_CHAN; c++) begin
      c_data_d.rem[c] = NUM_W'(b_left_q[c]) * NUM_W'(b_x_q)
                      + NUM_W'(b_right_q[c]) * NUM_W'(b_wx_q);
      c_data_d.quo[c] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      a_vld_q <= vld_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_x_q     <= a_x_d;
    a_y_q     <= a_y_d;
    a_wx_q    <= dim_w_i - a_x_d;
    a_hy_q    <= dim_h_i - a_y_d;
    a_w_q     <= dim_w_i;
    a_h_q     <= dim_h_i;
    b_left_q  <= b_left_d;
    b_right_q <= b_right_d;
    b_x_q     <= a_x_q;
    b_wx_q    <= a_wx_q;
    b_dvs_q   <= D_W'(a_w_q) * D_W'(a_h_q);
    c_data_q  <= c_data_d;
  end

  assign vld_o  = c_vld_q;
  assign data_o = c_data_q;

endmodule

`default_nettype wire

// File: design/fcg_div_cell.sv
// ----------------------------------------------------------------------------
// fcg_div_cell
// One restoring division step for all three channels; yields one
// quotient bit each and hands the item to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module fcg_div_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  fcg_pkg::div_data_t data_i,
  output logic               vld_o,
  output fcg_pkg::div_data_t data_o
);
  import fcg_pkg::*;

  logic             vld_q;
  div_data_t        data_d, data_q;
  logic [NUM_W-1:0] step;

  // remainder stays below divisor times 2^CHAN_W, so test against the top bit
  assign step = NUM_W'({data_i.dvs, {(CHAN_W - 1){1'b0}}});

  always_comb begin
    data_d = data_i;
    for (int unsigned c = 0; c < NUM_CHAN; c++) begin
      if (data_i.rem[c] >= step) begin
        data_d.rem[c] = (data_i.rem[c] - step) << 1;
        data_d.quo[c] = {data_i.quo[c][CHAN_W-2:0], 1'b1};
      end else begin
        data_d.rem[c] = data_i.rem[c] << 1;
        data_d.quo[c] = {data_i.quo[c][CHAN_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

`default_nettype wire
